[rtl/smeu_pkg.sv]
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types, operation codes and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int WORD_BITS_DEF   = 32;
    localparam int RET_SLOT_GAP    = 3;

    localparam logic [4:0] OP_PUSH   = 5'd0;
    localparam logic [4:0] OP_POP    = 5'd1;
    localparam logic [4:0] OP_ADD    = 5'd2;
    localparam logic [4:0] OP_SUB    = 5'd3;
    localparam logic [4:0] OP_MUL    = 5'd4;
    localparam logic [4:0] OP_GT     = 5'd5;
    localparam logic [4:0] OP_LT     = 5'd6;
    localparam logic [4:0] OP_JMP    = 5'd7;
    localparam logic [4:0] OP_BEQ0   = 5'd8;
    localparam logic [4:0] OP_ENTRY  = 5'd9;
    localparam logic [4:0] OP_FRAME  = 5'd10;
    localparam logic [4:0] OP_STOREL = 5'd11;
    localparam logic [4:0] OP_LOADL  = 5'd12;
    localparam logic [4:0] OP_CALL   = 5'd13;
    localparam logic [4:0] OP_RET    = 5'd14;
    localparam logic [4:0] OP_LOADA  = 5'd15;
    localparam logic [4:0] OP_STOREA = 5'd16;
    localparam logic [4:0] OP_POPR   = 5'd17;
    localparam logic [4:0] OP_END    = 5'd18;

    localparam logic [2:0] FLOW_SEQ   = 3'd0;
    localparam logic [2:0] FLOW_JUMP  = 3'd1;
    localparam logic [2:0] FLOW_CALL  = 3'd2;
    localparam logic [2:0] FLOW_RET   = 3'd3;
    localparam logic [2:0] FLOW_HALT  = 3'd4;
    localparam logic [2:0] FLOW_FAULT = 3'd5;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVER  = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;
    localparam logic [1:0] FAULT_FRAME = 2'd3;

    typedef struct packed {
        logic [4:0]  operation;
        logic [7:0]  argument;
        logic [15:0] current_pc;
    } instr_t;

    typedef struct packed {
        logic [2:0]         flow;
        logic [15:0]        target;
        logic signed [31:0] top_value;
        logic [8:0]         stack_depth;
        logic [1:0]         fault_code;
    } result_t;

endpackage

[rtl/smeu_alu.sv]
// ----------------------------------------------------------------------------
// smeu_alu
// Shared arithmetic unit: add, sub, multiply and signed compares, registered.
// ----------------------------------------------------------------------------
module smeu_alu #(
    parameter int WORD_BITS = smeu_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic [4:0]           op,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic [WORD_BITS-1:0] result
);

    logic [WORD_BITS-1:0] res_next;
    logic [WORD_BITS-1:0] result_reg;

    // a is second, b is top
    always_comb
    begin
        unique case (op)
            smeu_pkg::OP_ADD: res_next = a + b;
            smeu_pkg::OP_SUB: res_next = a - b;
            smeu_pkg::OP_MUL: res_next = a * b;
            smeu_pkg::OP_GT:  res_next = WORD_BITS'($signed(a) > $signed(b));
            smeu_pkg::OP_LT:  res_next = WORD_BITS'($signed(a) < $signed(b));
            default:          res_next = b;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign result = result_reg;

endmodule

[rtl/stack_machine_execute_unit.sv]
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Execute stage of a stack machine with frames, driven by a small sequencer
// around a stack memory with one read and one write port and one shared ALU.
// ----------------------------------------------------------------------------
// An instruction is taken only in the idle state, and the next one waits until
// the sequencer has finished the last and registered its result; a stalled
// result holds the sequencer until it is taken. Reset clears depth, frame
// base, entry and halt flags; stack contents are undefined until written.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
    parameter int WORD_BITS   = smeu_pkg::WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smeu_pkg::instr_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output smeu_pkg::result_t out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = AW + 1;
    localparam int CW = DW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_ALU   = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_RET1  = 4'd6;
    localparam logic [3:0] S_RET2  = 4'd7;
    localparam logic [3:0] S_RET3  = 4'd8;
    localparam logic [3:0] S_TOP   = 4'd9;
    localparam logic [3:0] S_TOPW  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_CALL2 = 4'd13;
    localparam logic [3:0] S_RETB  = 4'd14;

    logic [WORD_BITS-1:0] mem [STACK_DEPTH];

    logic [3:0]           state_reg, state_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [DW-1:0]        base_reg, base_next;
    logic                 entry_reg, entry_next;
    logic                 halted_reg, halted_next;
    smeu_pkg::instr_t     ins_reg, ins_next;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_BITS-1:0] op1_reg, op1_next;     // first read (top)
    logic [WORD_BITS-1:0] op2_reg, op2_next;     // second read
    logic [DW-1:0]        cnt_reg, cnt_next;
    logic [2:0]           flow_reg, flow_next;
    logic [15:0]          target_reg, target_next;
    logic [1:0]           fault_reg, fault_next;
    logic [WORD_BITS-1:0] top_reg, top_next;
    smeu_pkg::result_t    out_reg;
    logic                 out_valid_reg;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] alu_res;
    logic                 accept;

    smeu_alu #(.WORD_BITS(WORD_BITS)) u_alu (
        .clk    (clk),
        .op     (ins_reg.operation),
        .a      (op2_reg),
        .b      (op1_reg),
        .result (alu_res)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Check helpers on the latched instruction
    logic [CW-1:0] d_w, b_w, a_w, loc_w, arg_w;
    logic          arg_ok;
    logic [DW-1:0] arg_slot;
    always_comb
    begin
        d_w    = CW'(depth_reg);
        b_w    = CW'(base_reg);
        a_w    = CW'(ins_reg.argument);
        loc_w  = b_w + a_w;
        arg_ok = b_w >= a_w + CW'(smeu_pkg::RET_SLOT_GAP);
        arg_w  = b_w - a_w - CW'(smeu_pkg::RET_SLOT_GAP);
        arg_slot = arg_w[DW-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        base_next   = base_reg;
        entry_next  = entry_reg;
        halted_next = halted_reg;
        ins_next    = ins_reg;
        op1_next    = op1_reg;
        op2_next    = op2_reg;
        cnt_next    = cnt_reg;
        flow_next   = flow_reg;
        target_next = target_reg;
        fault_next  = fault_reg;
        top_next    = top_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ins_next    = in_data;
                    flow_next   = smeu_pkg::FLOW_SEQ;
                    target_next = '0;
                    fault_next  = smeu_pkg::FAULT_NONE;
                    state_next  = S_RD1;
                end
            end
            // Decode, check and issue the first access
            S_RD1:
            begin
                state_next = S_TOP;
                if (halted_reg)
                begin
                    flow_next = smeu_pkg::FLOW_HALT;
                end
                else
                begin
                    entry_next = (ins_reg.operation == smeu_pkg::OP_ENTRY);
                    unique case (ins_reg.operation) inside
                        smeu_pkg::OP_PUSH:
                        begin
                            if (d_w >= CW'(STACK_DEPTH)) fault_next = smeu_pkg::FAULT_OVER;
                            else
                            begin
                                wr_en = 1'b1;
                                wr_addr = depth_reg[AW-1:0];
                                wr_data = WORD_BITS'(ins_reg.argument);
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        smeu_pkg::OP_POP:
                        begin
                            if (depth_reg == '0) fault_next = smeu_pkg::FAULT_UNDER;
                            else depth_next = depth_reg - 1'b1;
                        end
                        smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
                        smeu_pkg::OP_GT, smeu_pkg::OP_LT:
                        begin
                            if (d_w < CW'(2)) fault_next = smeu_pkg::FAULT_UNDER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                state_next = S_RD2;
                            end
                        end
                        smeu_pkg::OP_JMP:
                        begin
                            flow_next = smeu_pkg::FLOW_JUMP;
                            target_next = 16'(ins_reg.argument);
                        end
                        smeu_pkg::OP_BEQ0:
                        begin
                            if (depth_reg == '0) fault_next = smeu_pkg::FAULT_UNDER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                depth_next = depth_reg - 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        smeu_pkg::OP_ENTRY: base_next = depth_reg;
                        smeu_pkg::OP_FRAME:
                        begin
                            if (!entry_reg) fault_next = smeu_pkg::FAULT_FRAME;
                            else if (d_w + a_w > CW'(STACK_DEPTH))
                                fault_next = smeu_pkg::FAULT_OVER;
                            else
                            begin
                                cnt_next = DW'(ins_reg.argument);
                                state_next = S_FILL;
                            end
                        end
                        smeu_pkg::OP_STOREL:
                        begin
                            if (depth_reg == '0 || loc_w >= d_w)
                                fault_next = smeu_pkg::FAULT_UNDER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                cnt_next = loc_w[DW-1:0];
                                state_next = S_WR;
                            end
                        end
                        smeu_pkg::OP_LOADL:
                        begin
                            if (loc_w >= d_w) fault_next = smeu_pkg::FAULT_UNDER;
                            else if (d_w >= CW'(STACK_DEPTH)) fault_next = smeu_pkg::FAULT_OVER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = loc_w[AW-1:0];
                                cnt_next = depth_reg;
                                depth_next = depth_reg + 1'b1;
                                state_next = S_WR;
                            end
                        end
                        smeu_pkg::OP_CALL:
                        begin
                            if (d_w + CW'(2) > CW'(STACK_DEPTH)) fault_next = smeu_pkg::FAULT_OVER;
                            else
                            begin
                                wr_en = 1'b1;
                                wr_addr = depth_reg[AW-1:0];
                                wr_data = WORD_BITS'(ins_reg.current_pc);
                                state_next = S_CALL2;
                            end
                        end
                        smeu_pkg::OP_RET:
                        begin
                            if (base_reg < DW'(2) || base_reg > depth_reg)
                                fault_next = smeu_pkg::FAULT_UNDER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                state_next = S_RET1;
                            end
                        end
                        smeu_pkg::OP_LOADA:
                        begin
                            if (!arg_ok || arg_w >= d_w) fault_next = smeu_pkg::FAULT_UNDER;
                            else if (d_w >= CW'(STACK_DEPTH)) fault_next = smeu_pkg::FAULT_OVER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = arg_slot[AW-1:0];
                                cnt_next = depth_reg;
                                depth_next = depth_reg + 1'b1;
                                state_next = S_WR;
                            end
                        end
                        smeu_pkg::OP_STOREA:
                        begin
                            if (depth_reg == '0 || !arg_ok || arg_w >= d_w - CW'(1))
                                fault_next = smeu_pkg::FAULT_UNDER;
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                cnt_next = arg_slot;
                                depth_next = depth_reg - 1'b1;
                                state_next = S_WR;
                            end
                        end
                        smeu_pkg::OP_POPR:
                        begin
                            if (d_w < a_w + CW'(1)) fault_next = smeu_pkg::FAULT_UNDER;
                            else if (ins_reg.argument != '0)
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(depth_reg - 1'b1);
                                cnt_next = depth_reg - DW'(ins_reg.argument) - 1'b1;
                                depth_next = depth_reg - DW'(ins_reg.argument);
                                state_next = S_WR;
                            end
                        end
                        smeu_pkg::OP_END:
                        begin
                            halted_next = 1'b1;
                            flow_next = smeu_pkg::FLOW_HALT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD2:
            begin
                // rd_data holds top
                op1_next = rd_data_reg;
                rd_en = 1'b1;
                rd_addr = AW'(depth_reg - DW'(2));
                state_next = S_ALU;
            end
            S_ALU:
            begin
                // rd_data holds second
                op2_next = rd_data_reg;
                state_next = S_RET3;
            end
            S_RET3:
            begin
                if (ins_reg.operation == smeu_pkg::OP_RET)
                begin
                    // rd_data is saved pc
                    flow_next   = smeu_pkg::FLOW_RET;
                    target_next = rd_data_reg[15:0] + 16'd1;
                    wr_en   = 1'b1;
                    wr_addr = AW'(depth_reg - 1'b1);
                    wr_data = op1_reg;
                    state_next = S_TOP;
                end
                else
                begin
                    op2_next = rd_data_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // alu result registered this cycle
                state_next = S_DONE;
                cnt_next = '1;
            end
            S_DONE:
            begin
                if (ins_reg.operation == smeu_pkg::OP_BEQ0)
                begin
                    if (rd_data_reg == '0)
                    begin
                        flow_next   = smeu_pkg::FLOW_JUMP;
                        target_next = 16'(ins_reg.argument);
                    end
                    state_next = S_TOP;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(depth_reg - DW'(2));
                    wr_data = alu_res;
                    depth_next = depth_reg - 1'b1;
                    state_next = S_TOP;
                end
            end
            S_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_data = rd_data_reg;
                state_next = S_TOP;
            end
            S_CALL2:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(depth_reg + 1'b1);
                wr_data = WORD_BITS'(base_reg);
                depth_next = depth_reg + DW'(2);
                base_next  = depth_reg + DW'(2);
                flow_next   = smeu_pkg::FLOW_CALL;
                target_next = 16'(ins_reg.argument);
                state_next = S_TOP;
            end
            S_FILL:
            begin
                if (cnt_reg == '0) state_next = S_TOP;
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = depth_reg[AW-1:0];
                    wr_data = '0;
                    depth_next = depth_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_RET1:
            begin
                // hold kept top, read saved base
                op1_next = rd_data_reg;
                rd_en = 1'b1;
                rd_addr = AW'(base_reg - 1'b1);
                state_next = S_RET2;
            end
            S_RET2:
            begin
                op2_next = rd_data_reg;      // saved base
                rd_en = 1'b1;
                rd_addr = AW'(base_reg - DW'(2));
                state_next = S_RETB;
            end
            S_RETB: // restore base from saved word
            begin
                if (op2_reg > WORD_BITS'(STACK_DEPTH)) base_next = DW'(STACK_DEPTH);
                else base_next = op2_reg[DW-1:0];
                depth_next = base_reg - 1'b1;
                state_next = S_RET3;
            end
            S_TOP:
            begin
                if (fault_reg != smeu_pkg::FAULT_NONE)
                begin
                    flow_next = smeu_pkg::FLOW_FAULT;
                    target_next = '0;
                end
                if (depth_reg != '0)
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(depth_reg - 1'b1);
                end
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                top_next = (depth_reg == '0) ? '0 : rd_data_reg;
                if (!out_valid_reg || out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            base_reg      <= '0;
            entry_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            base_reg   <= base_next;
            entry_reg  <= entry_next;
            halted_reg <= halted_next;
            if (state_reg == S_TOPW && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [31:0] top_ext;
    always_comb
    begin
        top_ext = 32'($signed(top_next));
    end

    always_ff @(posedge clk)
    begin
        ins_reg    <= ins_next;
        op1_reg    <= op1_next;
        op2_reg    <= op2_next;
        cnt_reg    <= cnt_next;
        flow_reg   <= flow_next;
        target_reg <= target_next;
        fault_reg  <= fault_next;
        top_reg    <= top_next;
        if (state_reg == S_TOPW && (!out_valid_reg || out_ready))
        begin
            out_reg.flow        <= flow_reg;
            out_reg.target      <= target_reg;
            out_reg.top_value   <= top_ext;
            out_reg.stack_depth <= 9'(depth_reg);
            out_reg.fault_code  <= fault_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/smeu_checker.sv]
// ----------------------------------------------------------------------------
// smeu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module smeu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input smeu_pkg::result_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    a_fault_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fault_code != smeu_pkg::FAULT_NONE |->
        out_data.flow == smeu_pkg::FLOW_FAULT && out_data.target == 16'd0)
        else $error("fault without fault flow");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stack_depth == 9'd0 |-> out_data.top_value == 32'sd0)
        else $error("nonzero top on empty stack");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[verif/tb_stack_machine_execute_unit.sv]
// ----------------------------------------------------------------------------
// tb_stack_machine_execute_unit
// Drives instruction streams into the execute unit, predicts every result
// from a model of the stack, depth, frame base and halt state, and compares
// each result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SDEPTH      = smeu_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 900000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    smeu_pkg::instr_t  in_data;
    logic              out_valid;
    logic              out_ready;
    smeu_pkg::result_t out_data;

    // predictor state
    logic [31:0] mdl_mem [SDEPTH];
    int          mdl_depth;
    int          mdl_base;
    bit          mdl_entry;
    bit          mdl_halted;

    smeu_pkg::result_t expected_results[$];
    int                fail_count;
    int                cycle_count;
    bit                idle_enable;

    stack_machine_execute_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL stack_machine_execute_unit");
                $finish;
            end
        end
    end

    function automatic smeu_pkg::result_t predict_step(smeu_pkg::instr_t ins);
        smeu_pkg::result_t r;
        int                d;
        int                s;
        bit                was_entry;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       v;
        logic [31:0]       keep;
        logic [31:0]       nb;
        logic [31:0]       rp;
        int                arg;
        r = '0;
        d = mdl_depth;
        arg = ins.argument;
        if (mdl_halted)
        begin
            r.flow = smeu_pkg::FLOW_HALT;
        end
        else
        begin
            was_entry = mdl_entry;
            mdl_entry = (ins.operation == smeu_pkg::OP_ENTRY);
            r.flow = smeu_pkg::FLOW_SEQ;
            r.fault_code = smeu_pkg::FAULT_NONE;
            case (ins.operation) inside
                smeu_pkg::OP_PUSH:
                    if (d >= SDEPTH) r.fault_code = smeu_pkg::FAULT_OVER;
                    else mdl_mem[mdl_depth++] = {24'd0, ins.argument};
                smeu_pkg::OP_POP:
                    if (d < 1) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else mdl_depth--;
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
                smeu_pkg::OP_GT, smeu_pkg::OP_LT:
                    if (d < 2) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else
                    begin
                        a = mdl_mem[d-1];
                        b = mdl_mem[d-2];
                        case (ins.operation)
                            smeu_pkg::OP_ADD: v = b + a;
                            smeu_pkg::OP_SUB: v = b - a;
                            smeu_pkg::OP_MUL: v = b * a;
                            smeu_pkg::OP_GT:  v = ($signed(b) > $signed(a)) ? 32'd1 : 32'd0;
                            default: v = ($signed(b) < $signed(a)) ? 32'd1 : 32'd0;
                        endcase
                        mdl_mem[d-2] = v;
                        mdl_depth = d - 1;
                    end
                smeu_pkg::OP_JMP:
                begin
                    r.flow = smeu_pkg::FLOW_JUMP;
                    r.target = 16'(arg);
                end
                smeu_pkg::OP_BEQ0:
                    if (d < 1) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else
                    begin
                        mdl_depth--;
                        if (mdl_mem[d-1] == 0)
                        begin
                            r.flow = smeu_pkg::FLOW_JUMP;
                            r.target = 16'(arg);
                        end
                    end
                smeu_pkg::OP_ENTRY:
                    mdl_base = d;
                smeu_pkg::OP_FRAME:
                    if (!was_entry) r.fault_code = smeu_pkg::FAULT_FRAME;
                    else if (d + arg > SDEPTH) r.fault_code = smeu_pkg::FAULT_OVER;
                    else
                        for (int i = 0; i < arg; i++) mdl_mem[mdl_depth++] = '0;
                smeu_pkg::OP_STOREL:
                begin
                    s = mdl_base + arg;
                    if (d < 1 || s >= d) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else mdl_mem[s] = mdl_mem[d-1];
                end
                smeu_pkg::OP_LOADL:
                begin
                    s = mdl_base + arg;
                    if (s >= d) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else if (d >= SDEPTH) r.fault_code = smeu_pkg::FAULT_OVER;
                    else mdl_mem[mdl_depth++] = mdl_mem[s];
                end
                smeu_pkg::OP_CALL:
                    if (d + 2 > SDEPTH) r.fault_code = smeu_pkg::FAULT_OVER;
                    else
                    begin
                        mdl_mem[d]   = {16'd0, ins.current_pc};
                        mdl_mem[d+1] = 32'(mdl_base);
                        mdl_depth = d + 2;
                        mdl_base = d + 2;
                        r.flow = smeu_pkg::FLOW_CALL;
                        r.target = 16'(arg);
                    end
                smeu_pkg::OP_RET:
                    if (mdl_base < 2 || mdl_base > d) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else
                    begin
                        keep = (d == 0) ? 32'd0 : mdl_mem[d-1];
                        nb = mdl_mem[mdl_base-1];
                        rp = mdl_mem[mdl_base-2];
                        mdl_depth = mdl_base - 2;
                        mdl_base = (nb > SDEPTH) ? SDEPTH : int'(nb);
                        mdl_mem[mdl_depth++] = keep;
                        r.flow = smeu_pkg::FLOW_RET;
                        r.target = rp[15:0] + 16'd1;
                    end
                smeu_pkg::OP_LOADA:
                    if (mdl_base < arg + smeu_pkg::RET_SLOT_GAP ||
                        mdl_base - arg - smeu_pkg::RET_SLOT_GAP >= d)
                        r.fault_code = smeu_pkg::FAULT_UNDER;
                    else if (d >= SDEPTH) r.fault_code = smeu_pkg::FAULT_OVER;
                    else mdl_mem[mdl_depth++] =
                        mdl_mem[mdl_base - arg - smeu_pkg::RET_SLOT_GAP];
                smeu_pkg::OP_STOREA:
                    if (d < 1 || mdl_base < arg + smeu_pkg::RET_SLOT_GAP ||
                        mdl_base - arg - smeu_pkg::RET_SLOT_GAP >= d - 1)
                        r.fault_code = smeu_pkg::FAULT_UNDER;
                    else
                    begin
                        mdl_depth--;
                        mdl_mem[mdl_base - arg - smeu_pkg::RET_SLOT_GAP] = mdl_mem[d-1];
                    end
                smeu_pkg::OP_POPR:
                    if (d < arg + 1) r.fault_code = smeu_pkg::FAULT_UNDER;
                    else
                    begin
                        mdl_mem[d-1-arg] = mdl_mem[d-1];
                        mdl_depth = d - arg;
                    end
                smeu_pkg::OP_END:
                begin
                    mdl_halted = 1'b1;
                    r.flow = smeu_pkg::FLOW_HALT;
                end
                default: ;
            endcase
            if (r.fault_code != smeu_pkg::FAULT_NONE)
            begin
                r.flow = smeu_pkg::FLOW_FAULT;
                r.target = '0;
            end
        end
        r.top_value = (mdl_depth == 0) ? 32'sd0 : $signed(mdl_mem[mdl_depth-1]);
        r.stack_depth = 9'(mdl_depth);
        return r;
    endfunction

    task automatic idle_cycles(int max_gap);
        int n;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, max_gap);
            repeat (n) @(negedge clk);
        end
    endtask

    // present one instruction and hold it until the transfer
    task automatic send_instr(logic [4:0] op, logic [7:0] arg, logic [15:0] pc);
        in_valid = 1'b1;
        in_data  = '{operation: op, argument: arg, current_pc: pc};
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_step(in_data));
        @(negedge clk);
        in_valid = 1'b0;
        idle_cycles(10);
    endtask

    task automatic send_rand(logic [4:0] op);
        send_instr(op, 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        smeu_pkg::result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_data.flow !== e.flow)
                begin
                    $error("flow exp %0d got %0d", e.flow, out_data.flow);
                    fail_count++;
                end
                if (out_data.target !== e.target)
                begin
                    $error("target exp %0d got %0d", e.target, out_data.target);
                    fail_count++;
                end
                if (out_data.top_value !== e.top_value)
                begin
                    $error("top_value exp %0d got %0d", e.top_value, out_data.top_value);
                    fail_count++;
                end
                if (out_data.stack_depth !== e.stack_depth)
                begin
                    $error("stack_depth exp %0d got %0d", e.stack_depth,
                           out_data.stack_depth);
                    fail_count++;
                end
                if (out_data.fault_code !== e.fault_code)
                begin
                    $error("fault_code exp %0d got %0d", e.fault_code,
                           out_data.fault_code);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_rand(smeu_pkg::OP_POP);                      // underflow on empty
        send_rand(smeu_pkg::OP_ADD);
        send_instr(smeu_pkg::OP_PUSH, 8'hFF, 16'h0000);
        send_instr(smeu_pkg::OP_PUSH, 8'h00, 16'hFFFF);
        send_instr(smeu_pkg::OP_SUB, 8'h00, 16'h0001);    // 255 minus 0
        send_instr(smeu_pkg::OP_PUSH, 8'h80, 16'h0002);
        send_instr(smeu_pkg::OP_MUL, 8'h00, 16'h0003);
        send_instr(smeu_pkg::OP_PUSH, 8'h01, 16'h0004);
        send_instr(smeu_pkg::OP_GT, 8'h00, 16'h0005);
        send_instr(smeu_pkg::OP_PUSH, 8'h01, 16'h0006);
        send_instr(smeu_pkg::OP_LT, 8'h00, 16'h0007);
        send_instr(smeu_pkg::OP_BEQ0, 8'h42, 16'h0008);
        send_instr(smeu_pkg::OP_JMP, 8'hFF, 16'h0009);
        send_instr(smeu_pkg::OP_FRAME, 8'h02, 16'h000A);  // frame not after entry
        send_instr(smeu_pkg::OP_PUSH, 8'h07, 16'h000B);
        send_instr(smeu_pkg::OP_CALL, 8'h05, 16'hFFFF);
        send_instr(smeu_pkg::OP_ENTRY, 8'h00, 16'h000C);
        send_instr(smeu_pkg::OP_FRAME, 8'h02, 16'h000D);
        send_instr(smeu_pkg::OP_LOADA, 8'h00, 16'h000E);
        send_instr(smeu_pkg::OP_STOREL, 8'h01, 16'h000F);
        send_instr(smeu_pkg::OP_LOADL, 8'h01, 16'h0010);
        send_instr(smeu_pkg::OP_STOREA, 8'h00, 16'h0011);
        send_instr(smeu_pkg::OP_POPR, 8'h01, 16'h0012);
        send_instr(smeu_pkg::OP_RET, 8'h00, 16'h0013);
        send_instr(5'd31, 8'h00, 16'h0014);               // unused code acts as nop
    endtask

    // fill to the top and overflow push, loadl, call and frame
    task automatic test_overflow();
        while (mdl_depth < SDEPTH) send_rand(smeu_pkg::OP_PUSH);
        send_rand(smeu_pkg::OP_PUSH);
        send_instr(smeu_pkg::OP_LOADL, 8'h00, 16'($urandom));
        send_rand(smeu_pkg::OP_CALL);
        send_instr(smeu_pkg::OP_ENTRY, 8'h00, 16'h0);
        send_instr(smeu_pkg::OP_FRAME, 8'h01, 16'h0);
        send_instr(smeu_pkg::OP_POPR, 8'hFF, 16'($urandom));
        wait_drained();                                   // sender holds until all results in
        send_instr(smeu_pkg::OP_POPR, 8'hFE, 16'($urandom));
        send_rand(smeu_pkg::OP_POP);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            send_rand(5'($urandom_range(0, 31)));
        else if (sel < 16)
        begin
            send_rand(smeu_pkg::OP_CALL);
            send_rand(smeu_pkg::OP_ENTRY);
            send_instr(smeu_pkg::OP_FRAME, 8'($urandom_range(0, 4)), 16'($urandom));
        end
        else if (sel < 22)
            send_instr(smeu_pkg::OP_FRAME, 8'($urandom_range(0, 3)), 16'($urandom));
        else if (sel < 28)
            send_rand(smeu_pkg::OP_RET);
        else if (sel < 40)
            send_rand(smeu_pkg::OP_PUSH);
        else if (sel < 55)
            send_rand(5'($urandom_range(smeu_pkg::OP_ADD, smeu_pkg::OP_LT)));
        else if (sel < 62)
            send_rand((mdl_depth > 200) ? smeu_pkg::OP_POP : smeu_pkg::OP_PUSH);
        else if (sel < 72)
            send_instr($urandom_range(0, 1) ? smeu_pkg::OP_LOADL : smeu_pkg::OP_STOREL,
                       8'($urandom_range(0, 5)), 16'($urandom));
        else if (sel < 82)
            send_instr($urandom_range(0, 1) ? smeu_pkg::OP_LOADA : smeu_pkg::OP_STOREA,
                       8'($urandom_range(0, 3)), 16'($urandom));
        else if (sel < 88)
            send_instr(smeu_pkg::OP_POPR, 8'($urandom_range(0, 4)), 16'($urandom));
        else if (sel < 94)
            send_rand(smeu_pkg::OP_BEQ0);
        else
            send_rand(smeu_pkg::OP_JMP);
    endtask

    task automatic test_random(int n);
        repeat (n) random_item();
    endtask

    task automatic test_halt();
        send_rand(smeu_pkg::OP_END);
        repeat (6) send_rand(5'($urandom_range(0, 31)));
    endtask

    initial
    begin
        fail_count  = 0;
        idle_enable = 1'b1;
        mdl_depth   = 0;
        mdl_base    = 0;
        mdl_entry   = 1'b0;
        mdl_halted  = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_overflow();
        test_random(500);
        idle_enable = 1'b0;
        test_random(170);
        test_halt();
        wait_drained();
        if (fail_count == 0)
            $display("PASS stack_machine_execute_unit");
        else
            $display("FAIL stack_machine_execute_unit");
        $finish;
    end

endmodule
